>>> rtl/link_recovery_ladder_defines.svh
// Assertion macros shared by the link recovery ladder RTL.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef LINK_RECOVERY_LADDER_DEFINES_SVH
`define LINK_RECOVERY_LADDER_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define LRL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside of reset.
`define LRL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/lrl_pkg.sv
// Types, constants and helpers for the link recovery ladder.
// Used by the channel interfaces, the policy logic and the top level.
package lrl_pkg;

  localparam int ModeW   = 3;
  localparam int RateW   = 3;
  localparam int ThrW    = 4;
  localparam int PeriodW = 5;
  localparam int PhaseW  = 4;
  localparam int MissW   = 4;
  localparam int FailW   = 8;
  localparam int AddrW   = 4;
  localparam int DataW   = 32;

  localparam logic [RateW-1:0]   RateMax    = 3'd5;
  localparam logic [RateW-1:0]   HealthyRst = 3'd3;
  localparam logic [ThrW-1:0]    ThrRst     = 4'd4;
  localparam logic [PeriodW-1:0] PeriodRst  = 5'd8;
  localparam logic [PeriodW-1:0] PeriodMax  = 5'd16;
  localparam logic [FailW-1:0]   FailMax    = 8'hFF;

  typedef enum logic [ModeW-1:0] {
    MODE_UPLINK   = 3'd0,
    MODE_PROBE    = 3'd1,
    MODE_JOIN_REQ = 3'd2,
    MODE_JOIN_RES = 3'd3,
    MODE_RESTORE  = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    REG_HEALTHY   = 2'd0,
    REG_THRESHOLD = 2'd1,
    REG_PERIOD    = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [RateW-1:0]   healthy_rate;
    logic [ThrW-1:0]    rejoin_threshold;
    logic [PeriodW-1:0] probe_period;
  } cfg_t;

  typedef struct packed {
    logic               joined_flag;
    logic               rejoin_marked;
    logic               probe_pending;
    logic [PhaseW-1:0]  uplink_phase;
    logic [MissW-1:0]   miss_count;
    logic               pinned_valid;
    logic [RateW-1:0]   pinned_rate;
    logic [FailW-1:0]   join_failures;
  } state_t;

  typedef struct packed {
    logic             confirmed;
    logic             not_joined;
    logic [RateW-1:0] data_rate;
    logic             adr_on;
    logic             degraded;
    logic             save_allowed;
  } result_t;

  // Healthy rate saturated to the highest defined rate.
  function automatic logic [RateW-1:0] healthy_eff(input logic [RateW-1:0] rate);
    return (rate > RateMax) ? RateMax : rate;
  endfunction

endpackage

>>> rtl/lrl_in_if.sv
// Request channel of the link recovery ladder: valid/ready plus event fields.
// Depends on lrl_pkg for the field widths.
interface lrl_in_if;
  logic                      valid;
  logic                      ready;
  logic [lrl_pkg::ModeW-1:0] mode;
  logic                      important;
  logic                      success;

  modport source(output valid, mode, important, success, input ready);
  modport sink(input valid, mode, important, success, output ready);
endinterface

>>> rtl/lrl_out_if.sv
// Result channel of the link recovery ladder: valid/ready plus result fields.
// Depends on lrl_pkg for the field widths.
interface lrl_out_if;
  logic                      valid;
  logic                      ready;
  logic                      confirmed;
  logic                      not_joined;
  logic [lrl_pkg::RateW-1:0] data_rate;
  logic                      adr_on;
  logic                      degraded;
  logic                      save_allowed;

  modport source(output valid, confirmed, not_joined, data_rate, adr_on, degraded,
                 save_allowed, input ready);
  modport sink(input valid, confirmed, not_joined, data_rate, adr_on, degraded,
               save_allowed, output ready);
endinterface

>>> rtl/link_recovery_ladder.sv
// Top level of the link recovery ladder: state, configuration and result registers.
// Depends on lrl_pkg, lrl_in_if, lrl_out_if, lrl_policy and the assertion macros.
//
// Usage: the node software sends one event request per uplink, probe outcome,
// join request, join outcome or session restore on in_ch, and gets exactly one
// result request back on out_ch for each. Both channels use valid/ready; a
// request moves at a rising edge where both are high.
// The result of an event accepted at one edge is shown on out_ch from the next
// cycle on. Throughput is one event per cycle while out_ch is not stalled, set
// by the single result register; the policy logic between the state registers
// and that register is a few small compares and adders.
// When the receiver stalls, the result register holds its request and in_ch
// ready drops until the result is taken; in the cycle it is taken a new event
// is accepted, so a steady stream never loses a cycle.
// Configuration goes through the APB port (healthy_rate at 0x0, rejoin_threshold
// at 0x4, probe_period at 0x8), is read back as written, and should only be
// changed while no event is in flight.
// Reset (rst_n low, synchronous) clears the session and ladder state, drops
// the result valid, and loads the register defaults 3, 4 and 8.
`include "link_recovery_ladder_defines.svh"

module link_recovery_ladder (
  input  logic                       clk,
  input  logic                       rst_n,
  lrl_in_if.sink                     in_ch,
  lrl_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lrl_pkg::AddrW-1:0]  paddr,
  input  logic [lrl_pkg::DataW-1:0]  pwdata,
  output logic [lrl_pkg::DataW-1:0]  prdata,
  output logic                       pready
);
  import lrl_pkg::*;

  cfg_t     cfg_r;
  state_t   state_r;
  state_t   state_nxt;
  result_t  res_nxt;
  result_t  out_r;
  logic     out_valid_r;
  logic     in_accept;
  logic     cfg_write;
  reg_idx_t reg_idx;

  // ---------------------------------------------------------------------------
  // Configuration port. Writes complete in the access phase; pready is tied
  // high so no wait states are inserted.
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_idx   = reg_idx_t'(paddr[AddrW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.healthy_rate     <= HealthyRst;
      cfg_r.rejoin_threshold <= ThrRst;
      cfg_r.probe_period     <= PeriodRst;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_HEALTHY:   cfg_r.healthy_rate     <= pwdata[RateW-1:0];
        REG_THRESHOLD: cfg_r.rejoin_threshold <= pwdata[ThrW-1:0];
        REG_PERIOD:    cfg_r.probe_period     <= pwdata[PeriodW-1:0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_HEALTHY:   prdata = DataW'(cfg_r.healthy_rate);
      REG_THRESHOLD: prdata = DataW'(cfg_r.rejoin_threshold);
      REG_PERIOD:    prdata = DataW'(cfg_r.probe_period);
      default:       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Event path. The policy step is purely combinational from the current state
  // and the incoming request; state and result are both captured at accept.
  // ---------------------------------------------------------------------------
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_accept   = in_ch.valid && in_ch.ready;

  lrl_policy u_policy (
    .cfg       (cfg_r),
    .st        (state_r),
    .mode      (in_ch.mode),
    .important (in_ch.important),
    .success   (in_ch.success),
    .st_nxt    (state_nxt),
    .res       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_accept) begin
      state_r <= state_nxt;
    end
  end

  // Result register: it loads on every accepted event and keeps its request
  // while the receiver stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_r <= res_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.confirmed    = out_r.confirmed;
  assign out_ch.not_joined   = out_r.not_joined;
  assign out_ch.data_rate    = out_r.data_rate;
  assign out_ch.adr_on       = out_r.adr_on;
  assign out_ch.degraded     = out_r.degraded;
  assign out_ch.save_allowed = out_r.save_allowed;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `LRL_ASSERT_IMP(a_no_accept_on_stall, out_valid_r && !out_ch.ready, !in_ch.ready,
                  "event accepted while the result register is stalled")
  `LRL_ASSERT_NXT(a_result_follows, in_accept, out_valid_r,
                  "accepted event produced no result request")
  `LRL_ASSERT_IMP(a_pending_needs_join, state_r.probe_pending, state_r.joined_flag,
                  "probe outcome pending without a joined session")
  `LRL_ASSERT_IMP(a_confirm_excl, out_valid_r, !(out_r.confirmed && out_r.not_joined),
                  "uplink both confirmed and refused")
  `LRL_ASSERT_IMP(a_degraded_no_adr, out_valid_r && out_r.degraded, !out_r.adr_on,
                  "adaptive rate on while a rate is pinned")

endmodule

>>> rtl/lrl_policy.sv
// Combinational policy step: next ladder state and the result for one event.
// Depends on lrl_pkg for the state, configuration and result types.
module lrl_policy (
  input  lrl_pkg::cfg_t                   cfg,
  input  lrl_pkg::state_t                 st,
  input  logic [lrl_pkg::ModeW-1:0]       mode,
  input  logic                            important,
  input  logic                            success,
  output lrl_pkg::state_t                 st_nxt,
  output lrl_pkg::result_t                res
);
  import lrl_pkg::*;

  logic [RateW-1:0]   healthy;
  logic [PeriodW-1:0] period;
  logic [PeriodW-1:0] phase_inc;
  logic               probe;
  logic [MissW:0]     miss_inc;
  logic [RateW-1:0]   base_rate;
  logic [RateW-1:0]   join_rate;
  logic               confirmed;
  logic               not_joined;
  logic               join_req;

  assign healthy   = healthy_eff(cfg.healthy_rate);
  assign period    = (cfg.probe_period == '0) ? PeriodW'(1) :
                     (cfg.probe_period > PeriodMax) ? PeriodMax : cfg.probe_period;
  assign phase_inc = {1'b0, st.uplink_phase} + PeriodW'(1);
  assign probe     = (phase_inc >= period);
  assign miss_inc  = {1'b0, st.miss_count} + (MissW+1)'(1);
  assign base_rate = st.pinned_valid ? st.pinned_rate : healthy;
  // Each earlier failed join lowers the join rate by one, down to zero.
  assign join_rate = (st.join_failures >= {{(FailW-RateW){1'b0}}, healthy}) ? '0 :
                     RateW'({{(FailW-RateW){1'b0}}, healthy} - st.join_failures);

  always_comb begin
    st_nxt     = st;
    confirmed  = 1'b0;
    not_joined = 1'b0;
    join_req   = 1'b0;
    case (mode_t'(mode))
      MODE_UPLINK: begin
        if (!st.joined_flag) begin
          not_joined = 1'b1;
        end else begin
          st_nxt.uplink_phase  = probe ? '0 : phase_inc[PhaseW-1:0];
          confirmed            = important | st.pinned_valid | probe;
          st_nxt.probe_pending = confirmed;
        end
      end
      MODE_PROBE: begin
        if (st.probe_pending) begin
          st_nxt.probe_pending = 1'b0;
          if (success) begin
            st_nxt.miss_count   = '0;
            st_nxt.pinned_valid = 1'b0;
          end else if (miss_inc >= {1'b0, cfg.rejoin_threshold}) begin
            st_nxt.rejoin_marked = 1'b1;
            st_nxt.miss_count    = '0;
            st_nxt.pinned_valid  = 1'b0;
          end else begin
            st_nxt.miss_count   = miss_inc[MissW-1:0];
            st_nxt.pinned_rate  = (base_rate == '0) ? '0 : base_rate - RateW'(1);
            st_nxt.pinned_valid = 1'b1;
          end
        end
      end
      MODE_JOIN_REQ: begin
        join_req = 1'b1;
      end
      MODE_JOIN_RES: begin
        st_nxt.probe_pending = 1'b0;
        if (success) begin
          st_nxt.join_failures = '0;
          st_nxt.miss_count    = '0;
          st_nxt.pinned_valid  = 1'b0;
          st_nxt.joined_flag   = 1'b1;
          st_nxt.rejoin_marked = 1'b0;
        end else begin
          st_nxt.joined_flag = 1'b0;
          if (st.join_failures != FailMax) begin
            st_nxt.join_failures = st.join_failures + FailW'(1);
          end
        end
      end
      MODE_RESTORE: begin
        st_nxt.probe_pending = 1'b0;
        st_nxt.joined_flag   = 1'b1;
        st_nxt.rejoin_marked = 1'b0;
      end
      default: begin
        st_nxt = st;
      end
    endcase
  end

  always_comb begin
    res.confirmed    = confirmed;
    res.not_joined   = not_joined;
    res.data_rate    = join_req ? join_rate :
                       (st_nxt.pinned_valid ? st_nxt.pinned_rate : healthy);
    res.adr_on       = !join_req && !st_nxt.pinned_valid;
    res.degraded     = st_nxt.pinned_valid;
    res.save_allowed = !st_nxt.rejoin_marked;
  end

endmodule
